// File: hdl/tdmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdmc_pkg
// Shared types and constants of the two-level direct-mapped tag lookup unit.
// ----------------------------------------------------------------------------
package tdmc_pkg;

	// request kinds
	localparam logic [1:0] REQ_READ     = 2'd0;
	localparam logic [1:0] REQ_WRITE    = 2'd1;
	localparam logic [1:0] REQ_PREFETCH = 2'd2;
	localparam logic [1:0] REQ_FLUSH    = 2'd3;

	// serving level codes
	localparam logic [1:0] LVL_L1  = 2'd0;
	localparam logic [1:0] LVL_L2  = 2'd1;
	localparam logic [1:0] LVL_MEM = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_L1_LAT  = 2'd0;
	localparam logic [1:0] CFG_L2_LAT  = 2'd1;
	localparam logic [1:0] CFG_MEM_LAT = 2'd2;

	// field widths
	localparam int LAT_W    = 10;
	localparam int CNT_W    = 32;
	localparam int TOT_W    = 64;
	localparam int BYTES_W  = 16;
	localparam int REQ_W    = 2;
	localparam int LVL_W    = 2;
	localparam int CIDX_W   = 2;
	// 64-byte lines
	localparam int LINE_OFF_W = 6;

	// result payload: latency, four counters, two totals, padded to bytes
	localparam int OUT_RAW_W = LAT_W + 4 * CNT_W + 2 * TOT_W;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	// register reset values
	localparam logic [LAT_W-1:0] L1_LAT_RST  = 10'd1;
	localparam logic [LAT_W-1:0] L2_LAT_RST  = 10'd10;
	localparam logic [LAT_W-1:0] MEM_LAT_RST = 10'd100;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clear;
		logic access;
		logic prefetch;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             out_free;
		logic             clr_last;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/tdmc_tag_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdmc_tag_store
// Direct-mapped tag memory; each entry holds a valid bit and a tag, one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module tdmc_tag_store #(
	parameter int LINES = 4096,
	parameter int TAG_W = 30
) (
	input  wire                      clk,
	input  wire  [$clog2(LINES)-1:0] rd_addr,
	output logic                     rd_valid,
	output logic [TAG_W-1:0]         rd_tag,
	input  wire                      wr_en,
	input  wire  [$clog2(LINES)-1:0] wr_addr,
	input  wire                      wr_valid,
	input  wire  [TAG_W-1:0]         wr_tag
);

	logic [TAG_W:0] mem [LINES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_valid, wr_tag};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		{rd_valid, rd_tag} <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: hdl/tdmc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdmc_ctrl
// Sequencer: clearing pass, item accept and lookup/commit steps.
// ----------------------------------------------------------------------------
module tdmc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire tdmc_pkg::sts_t sts,
	output tdmc_pkg::cmd_t      cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.clear    = 1'b0;
		cmd.access   = 1'b0;
		cmd.prefetch = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				case (sts.req_type)
					tdmc_pkg::REQ_FLUSH: begin
						state_d = S_CLEAR;
					end
					tdmc_pkg::REQ_PREFETCH: begin
						cmd.prefetch = 1'b1;
						state_d      = S_IDLE;
					end
					default: begin
						if (sts.out_free) begin
							cmd.access = 1'b1;
							state_d    = S_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/tdmc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdmc_datapath
// Tag stores, hit compare, fills, statistics, latency registers and the
// result register.
// ----------------------------------------------------------------------------
module tdmc_datapath #(
	parameter int L1_LINES  = 4096,
	parameter int L2_LINES  = 16384,
	parameter int ADDR_BITS = 48
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire tdmc_pkg::cmd_t                 cmd,
	output tdmc_pkg::sts_t                      sts,
	input  wire  [tdmc_pkg::REQ_W-1:0]          in_req_type,
	input  wire  [ADDR_BITS-1:0]                in_address,
	input  wire  [tdmc_pkg::BYTES_W-1:0]        in_access_bytes,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [tdmc_pkg::CIDX_W-1:0]         cfg_index,
	input  wire  [tdmc_pkg::LAT_W-1:0]          cfg_data,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [tdmc_pkg::LAT_W-1:0]          out_latency,
	output logic [tdmc_pkg::LVL_W-1:0]          out_hit_level,
	output logic [tdmc_pkg::CNT_W-1:0]          out_l1_hit_count,
	output logic [tdmc_pkg::CNT_W-1:0]          out_l1_access_count,
	output logic [tdmc_pkg::CNT_W-1:0]          out_l2_hit_count,
	output logic [tdmc_pkg::CNT_W-1:0]          out_l2_access_count,
	output logic [tdmc_pkg::TOT_W-1:0]          out_mem_read_bytes,
	output logic [tdmc_pkg::TOT_W-1:0]          out_mem_write_bytes
);

	localparam int L1_IW     = $clog2(L1_LINES);
	localparam int L2_IW     = $clog2(L2_LINES);
	localparam int L1_TAG_W  = ADDR_BITS - tdmc_pkg::LINE_OFF_W - L1_IW;
	localparam int L2_TAG_W  = ADDR_BITS - tdmc_pkg::LINE_OFF_W - L2_IW;
	localparam int MAX_LINES = (L1_LINES > L2_LINES) ? L1_LINES : L2_LINES;
	localparam int CW        = $clog2(MAX_LINES);

	// latched item
	logic [tdmc_pkg::REQ_W-1:0]   req_q;
	logic [ADDR_BITS-1:0]         addr_q;
	logic [tdmc_pkg::BYTES_W-1:0] bytes_q;

	// configuration
	logic [tdmc_pkg::LAT_W-1:0] l1_lat_q;
	logic [tdmc_pkg::LAT_W-1:0] l2_lat_q;
	logic [tdmc_pkg::LAT_W-1:0] mem_lat_q;

	// statistics
	logic [tdmc_pkg::CNT_W-1:0] l1_hits_q;
	logic [tdmc_pkg::CNT_W-1:0] l1_lookups_q;
	logic [tdmc_pkg::CNT_W-1:0] l2_hits_q;
	logic [tdmc_pkg::CNT_W-1:0] l2_lookups_q;
	logic [tdmc_pkg::TOT_W-1:0] rd_total_q;
	logic [tdmc_pkg::TOT_W-1:0] wr_total_q;

	logic [tdmc_pkg::CNT_W-1:0] l1_hits_d;
	logic [tdmc_pkg::CNT_W-1:0] l1_lookups_d;
	logic [tdmc_pkg::CNT_W-1:0] l2_hits_d;
	logic [tdmc_pkg::CNT_W-1:0] l2_lookups_d;
	logic [tdmc_pkg::TOT_W-1:0] rd_total_d;
	logic [tdmc_pkg::TOT_W-1:0] wr_total_d;

	// clearing pass counter
	logic [CW-1:0] clr_cnt_q;

	// tag store ports
	logic [ADDR_BITS-1:0] rd_addr;
	logic [L1_IW-1:0]     l1_rd_idx;
	logic [L2_IW-1:0]     l2_rd_idx;
	logic                 l1_rd_valid;
	logic [L1_TAG_W-1:0]  l1_rd_tag;
	logic                 l2_rd_valid;
	logic [L2_TAG_W-1:0]  l2_rd_tag;
	logic                 l1_wr_en;
	logic                 l2_wr_en;
	logic [L1_IW-1:0]     l1_wr_idx;
	logic [L2_IW-1:0]     l2_wr_idx;
	logic                 wr_valid;

	logic                       hit1;
	logic                       hit2;
	logic                       out_free;
	logic [tdmc_pkg::LVL_W-1:0] level;
	logic [tdmc_pkg::LAT_W-1:0] lat;

	assign cfg_ready = 1'b1;

	// read at the incoming address on accept, else at the latched one
	assign rd_addr   = cmd.load ? in_address : addr_q;
	assign l1_rd_idx = rd_addr[tdmc_pkg::LINE_OFF_W +: L1_IW];
	assign l2_rd_idx = rd_addr[tdmc_pkg::LINE_OFF_W +: L2_IW];

	// hit compare against the latched address
	assign hit1 = l1_rd_valid && (l1_rd_tag == addr_q[ADDR_BITS-1 -: L1_TAG_W]);
	assign hit2 = l2_rd_valid && (l2_rd_tag == addr_q[ADDR_BITS-1 -: L2_TAG_W]);

	// fill or clear writes
	assign wr_valid  = !cmd.clear;
	assign l1_wr_idx = cmd.clear ? clr_cnt_q[L1_IW-1:0]
	                             : addr_q[tdmc_pkg::LINE_OFF_W +: L1_IW];
	assign l2_wr_idx = cmd.clear ? clr_cnt_q[L2_IW-1:0]
	                             : addr_q[tdmc_pkg::LINE_OFF_W +: L2_IW];
	assign l1_wr_en  = cmd.clear ? ({1'b0, clr_cnt_q} < (CW+1)'(L1_LINES))
	                             : (cmd.prefetch || (cmd.access && !hit1));
	assign l2_wr_en  = cmd.clear ? ({1'b0, clr_cnt_q} < (CW+1)'(L2_LINES))
	                             : (cmd.prefetch || (cmd.access && !hit1 && !hit2));

	tdmc_tag_store #(
		.LINES (L1_LINES),
		.TAG_W (L1_TAG_W)
	) u_l1_tags (
		.clk      (clk),
		.rd_addr  (l1_rd_idx),
		.rd_valid (l1_rd_valid),
		.rd_tag   (l1_rd_tag),
		.wr_en    (l1_wr_en),
		.wr_addr  (l1_wr_idx),
		.wr_valid (wr_valid),
		.wr_tag   (addr_q[ADDR_BITS-1 -: L1_TAG_W])
	);

	tdmc_tag_store #(
		.LINES (L2_LINES),
		.TAG_W (L2_TAG_W)
	) u_l2_tags (
		.clk      (clk),
		.rd_addr  (l2_rd_idx),
		.rd_valid (l2_rd_valid),
		.rd_tag   (l2_rd_tag),
		.wr_en    (l2_wr_en),
		.wr_addr  (l2_wr_idx),
		.wr_valid (wr_valid),
		.wr_tag   (addr_q[ADDR_BITS-1 -: L2_TAG_W])
	);

	// serving level and its latency
	always_comb begin
		if (hit1) begin
			level = tdmc_pkg::LVL_L1;
		end else if (hit2) begin
			level = tdmc_pkg::LVL_L2;
		end else begin
			level = tdmc_pkg::LVL_MEM;
		end
		case (level)
			tdmc_pkg::LVL_L1: lat = l1_lat_q;
			tdmc_pkg::LVL_L2: lat = l2_lat_q;
			default:          lat = mem_lat_q;
		endcase
	end

	// statistics after this access
	always_comb begin
		l1_lookups_d = l1_lookups_q + {{(tdmc_pkg::CNT_W-1){1'b0}}, 1'b1};
		l1_hits_d    = l1_hits_q + {{(tdmc_pkg::CNT_W-1){1'b0}}, hit1};
		l2_lookups_d = l2_lookups_q + {{(tdmc_pkg::CNT_W-1){1'b0}}, !hit1};
		l2_hits_d    = l2_hits_q + {{(tdmc_pkg::CNT_W-1){1'b0}}, !hit1 && hit2};
		rd_total_d   = rd_total_q;
		wr_total_d   = wr_total_q;
		if (!hit1 && !hit2) begin
			if (req_q == tdmc_pkg::REQ_WRITE) begin
				wr_total_d = wr_total_q
				           + {{(tdmc_pkg::TOT_W-tdmc_pkg::BYTES_W){1'b0}}, bytes_q};
			end else begin
				rd_total_d = rd_total_q
				           + {{(tdmc_pkg::TOT_W-tdmc_pkg::BYTES_W){1'b0}}, bytes_q};
			end
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= in_req_type;
			addr_q  <= in_address;
			bytes_q <= in_access_bytes;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_lat_q  <= tdmc_pkg::L1_LAT_RST;
			l2_lat_q  <= tdmc_pkg::L2_LAT_RST;
			mem_lat_q <= tdmc_pkg::MEM_LAT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdmc_pkg::CFG_L1_LAT:  l1_lat_q  <= cfg_data;
				tdmc_pkg::CFG_L2_LAT:  l2_lat_q  <= cfg_data;
				tdmc_pkg::CFG_MEM_LAT: mem_lat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_hits_q    <= '0;
			l1_lookups_q <= '0;
			l2_hits_q    <= '0;
			l2_lookups_q <= '0;
			rd_total_q   <= '0;
			wr_total_q   <= '0;
		end else if (cmd.access) begin
			l1_hits_q    <= l1_hits_d;
			l1_lookups_q <= l1_lookups_d;
			l2_hits_q    <= l2_hits_d;
			l2_lookups_q <= l2_lookups_d;
			rd_total_q   <= rd_total_d;
			wr_total_q   <= wr_total_d;
		end
	end

	// clearing pass counter, wraps back to zero at the end of a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + {{(CW-1){1'b0}}, 1'b1};
		end
	end

	// result register
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.access) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access) begin
			out_latency         <= lat;
			out_hit_level       <= level;
			out_l1_hit_count    <= l1_hits_d;
			out_l1_access_count <= l1_lookups_d;
			out_l2_hit_count    <= l2_hits_d;
			out_l2_access_count <= l2_lookups_d;
			out_mem_read_bytes  <= rd_total_d;
			out_mem_write_bytes <= wr_total_d;
		end
	end

	// status to the controller
	assign sts.req_type = req_q;
	assign sts.out_free = out_free;
	assign sts.clr_last = (clr_cnt_q == CW'(MAX_LINES - 1));

endmodule
`default_nettype wire

// File: hdl/two_level_direct_mapped_cache_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_direct_mapped_cache_unit
// Two-level direct-mapped tag lookup with 64-byte lines, hit statistics and
// memory byte totals.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser req_type, tdata address, bytes
//  m_*      out  m_tvalid/m_tready    tuser hit_level, tdata latency, stats
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (latency registers)
//
// read, write and prefetch run as an accept step, which launches the
// registered tag reads of both levels, then a compare and fill step
// flush and reset run a clearing pass over the tag memories, during
// which no item is accepted
// a read or write waits in its compare step while the previous result is
// still held untaken in the output register
// line counts must be powers of two
// ----------------------------------------------------------------------------
module two_level_direct_mapped_cache_unit #(
	parameter int L1_LINES  = 4096,
	parameter int L2_LINES  = 16384,
	parameter int ADDR_BITS = 48
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// address, access_bytes
	input  wire  [((ADDR_BITS+tdmc_pkg::BYTES_W+7)/8)*8-1:0] s_tdata,
	// req_type
	input  wire  [tdmc_pkg::REQ_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// latency, l1_hit_count, l1_access_count, l2_hit_count,
	// l2_access_count, mem_read_bytes, mem_write_bytes
	output logic [tdmc_pkg::OUT_W-1:0]         m_tdata,
	// hit_level
	output logic [tdmc_pkg::LVL_W-1:0]         m_tuser,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [tdmc_pkg::CIDX_W-1:0]        cfg_index,
	input  wire  [tdmc_pkg::LAT_W-1:0]         cfg_data
);

	tdmc_pkg::cmd_t cmd;
	tdmc_pkg::sts_t sts;

	logic [tdmc_pkg::LAT_W-1:0] res_latency;
	logic [tdmc_pkg::CNT_W-1:0] l1_hit_count;
	logic [tdmc_pkg::CNT_W-1:0] l1_access_count;
	logic [tdmc_pkg::CNT_W-1:0] l2_hit_count;
	logic [tdmc_pkg::CNT_W-1:0] l2_access_count;
	logic [tdmc_pkg::TOT_W-1:0] mem_read_bytes;
	logic [tdmc_pkg::TOT_W-1:0] mem_write_bytes;

	tdmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdmc_datapath #(
		.L1_LINES  (L1_LINES),
		.L2_LINES  (L2_LINES),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.in_req_type         (s_tuser),
		.in_address          (s_tdata[ADDR_BITS-1:0]),
		.in_access_bytes     (s_tdata[ADDR_BITS +: tdmc_pkg::BYTES_W]),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.out_latency         (res_latency),
		.out_hit_level       (m_tuser),
		.out_l1_hit_count    (l1_hit_count),
		.out_l1_access_count (l1_access_count),
		.out_l2_hit_count    (l2_hit_count),
		.out_l2_access_count (l2_access_count),
		.out_mem_read_bytes  (mem_read_bytes),
		.out_mem_write_bytes (mem_write_bytes)
	);

	// result payload packing, highest field first, latency in the lowest bits
	assign m_tdata = {
		{(tdmc_pkg::OUT_W - tdmc_pkg::OUT_RAW_W){1'b0}},
		mem_write_bytes,
		mem_read_bytes,
		l2_access_count,
		l2_hit_count,
		l1_access_count,
		l1_hit_count,
		res_latency
	};

endmodule
`default_nettype wire
